// ===== rtl/msgpack_value_encoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// MessagePack value encoder: assertion macros
// Clocked assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef MSGPACK_VALUE_ENCODER_TOP_DEFINES_SVH
`define MSGPACK_VALUE_ENCODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked while out of reset.
`define MVE_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define MVE_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`else

`define MVE_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define MVE_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

// ===== rtl/mve_pkg.sv =====
// ----------------------------------------------------------------------------
// MessagePack value encoder package
// Modes, type bytes, queue sizing and the command passed front to back.
// ----------------------------------------------------------------------------
package mve_pkg;

  typedef enum logic [3:0] {
    MODE_NIL  = 4'd0,
    MODE_BOOL = 4'd1,
    MODE_UINT = 4'd2,
    MODE_INT  = 4'd3,
    MODE_STR  = 4'd4,
    MODE_BIN  = 4'd5,
    MODE_ARR  = 4'd6,
    MODE_MAP  = 4'd7,
    MODE_RAW  = 4'd8
  } mode_t;

  localparam logic [7:0] TB_NIL    = 8'hC0;
  localparam logic [7:0] TB_FALSE  = 8'hC2;
  localparam logic [7:0] TB_TRUE   = 8'hC3;
  localparam logic [7:0] TB_UINT8  = 8'hCC;
  localparam logic [7:0] TB_UINT16 = 8'hCD;
  localparam logic [7:0] TB_UINT32 = 8'hCE;
  localparam logic [7:0] TB_UINT64 = 8'hCF;
  localparam logic [7:0] TB_INT8   = 8'hD0;
  localparam logic [7:0] TB_INT16  = 8'hD1;
  localparam logic [7:0] TB_INT32  = 8'hD2;
  localparam logic [7:0] TB_INT64  = 8'hD3;
  localparam logic [7:0] TB_NEGFIX = 8'hE0;
  localparam logic [7:0] TB_FIXSTR = 8'hA0;
  localparam logic [7:0] TB_STR8   = 8'hD9;
  localparam logic [7:0] TB_STR16  = 8'hDA;
  localparam logic [7:0] TB_STR32  = 8'hDB;
  localparam logic [7:0] TB_BIN8   = 8'hC4;
  localparam logic [7:0] TB_BIN16  = 8'hC5;
  localparam logic [7:0] TB_BIN32  = 8'hC6;
  localparam logic [7:0] TB_FIXARR = 8'h90;
  localparam logic [7:0] TB_ARR16  = 8'hDC;
  localparam logic [7:0] TB_ARR32  = 8'hDD;
  localparam logic [7:0] TB_FIXMAP = 8'h80;
  localparam logic [7:0] TB_MAP16  = 8'hDE;
  localparam logic [7:0] TB_MAP32  = 8'hDF;

  // Trailing operand bytes after the lead byte: 0, 1, 2, 4 or 8.
  localparam int unsigned NB_W = 4;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0]      lead;
    logic [63:0]     value;
    logic [NB_W-1:0] nbytes;
  } cmd_t;

endpackage

// ===== rtl/mve_front.sv =====
// ----------------------------------------------------------------------------
// MessagePack encoder front end
// Accepts items, picks the shortest form, pushes one command per defined item.
// ----------------------------------------------------------------------------
module mve_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_mode,
  input  logic [63:0]       in_value,
  input  logic              q_full,
  output logic              push,
  output mve_pkg::cmd_t     cmd
);
  import mve_pkg::*;

  logic        known;
  logic [31:0] len;

  assign len      = in_value[31:0];
  assign in_stall = q_full;

  always_comb begin
    known      = 1'b1;
    cmd.value  = in_value;
    cmd.lead   = 8'h00;
    cmd.nbytes = NB_W'(0);
    case (mode_t'(in_mode))
      MODE_NIL:  cmd.lead = TB_NIL;
      MODE_BOOL: cmd.lead = (in_value != 64'd0) ? TB_TRUE : TB_FALSE;
      MODE_UINT, MODE_INT: begin
        if (!in_value[63] || (mode_t'(in_mode) == MODE_UINT)) begin
          if (in_value[63:7] == 57'd0) begin
            cmd.lead = in_value[7:0];
          end else if (in_value[63:8] == 56'd0) begin
            cmd.lead = TB_UINT8;  cmd.nbytes = NB_W'(1);
          end else if (in_value[63:16] == 48'd0) begin
            cmd.lead = TB_UINT16; cmd.nbytes = NB_W'(2);
          end else if (in_value[63:32] == 32'd0) begin
            cmd.lead = TB_UINT32; cmd.nbytes = NB_W'(4);
          end else begin
            cmd.lead = TB_UINT64; cmd.nbytes = NB_W'(8);
          end
        end else begin
          if (&in_value[63:5]) begin
            cmd.lead = in_value[7:0];
          end else if (&in_value[63:7]) begin
            cmd.lead = TB_INT8;  cmd.nbytes = NB_W'(1);
          end else if (&in_value[63:15]) begin
            cmd.lead = TB_INT16; cmd.nbytes = NB_W'(2);
          end else if (&in_value[63:31]) begin
            cmd.lead = TB_INT32; cmd.nbytes = NB_W'(4);
          end else begin
            cmd.lead = TB_INT64; cmd.nbytes = NB_W'(8);
          end
        end
      end
      MODE_STR: begin
        if (len[31:5] == 27'd0) begin
          cmd.lead = TB_FIXSTR | {3'b000, len[4:0]};
        end else if (len[31:8] == 24'd0) begin
          cmd.lead = TB_STR8;  cmd.nbytes = NB_W'(1);
        end else if (len[31:16] == 16'd0) begin
          cmd.lead = TB_STR16; cmd.nbytes = NB_W'(2);
        end else begin
          cmd.lead = TB_STR32; cmd.nbytes = NB_W'(4);
        end
      end
      MODE_BIN: begin
        if (len[31:8] == 24'd0) begin
          cmd.lead = TB_BIN8;  cmd.nbytes = NB_W'(1);
        end else if (len[31:16] == 16'd0) begin
          cmd.lead = TB_BIN16; cmd.nbytes = NB_W'(2);
        end else begin
          cmd.lead = TB_BIN32; cmd.nbytes = NB_W'(4);
        end
      end
      MODE_ARR, MODE_MAP: begin
        if (len[31:4] == 28'd0) begin
          cmd.lead = ((mode_t'(in_mode) == MODE_ARR) ? TB_FIXARR : TB_FIXMAP)
                     | {4'h0, len[3:0]};
        end else if (len[31:16] == 16'd0) begin
          cmd.lead   = (mode_t'(in_mode) == MODE_ARR) ? TB_ARR16 : TB_MAP16;
          cmd.nbytes = NB_W'(2);
        end else begin
          cmd.lead   = (mode_t'(in_mode) == MODE_ARR) ? TB_ARR32 : TB_MAP32;
          cmd.nbytes = NB_W'(4);
        end
      end
      MODE_RAW: cmd.lead = in_value[7:0];
      default:  known = 1'b0;  // undefined modes produce nothing
    endcase
  end

  assign push = in_valid && !q_full && known;

endmodule

// ===== rtl/mve_queue.sv =====
// ----------------------------------------------------------------------------
// MessagePack encoder command queue
// Small FIFO decoupling the classifier from the byte serializer.
// ----------------------------------------------------------------------------
module mve_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mve_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output mve_pkg::cmd_t head_cmd
);
  import mve_pkg::*;

  localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);
  localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(Q_DEPTH);

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full       = (cnt_r == CNT_FULL);
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/mve_back.sv =====
// ----------------------------------------------------------------------------
// MessagePack encoder back end
// Walks the head command byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module mve_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          head_valid,
  input  mve_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_last
);
  import mve_pkg::*;
  `include "msgpack_value_encoder_top_defines.svh"

  logic [NB_W-1:0] idx_r, idx_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      out_byte_r;
  logic            out_last_r;
  logic            load;
  logic            is_last;
  logic [NB_W-1:0] byte_sel;
  logic [63:0]     shifted;
  logic [7:0]      cur_byte;

  // Output register refills when empty or when its transaction completes.
  assign load    = head_valid && (!out_valid_r || !out_stall);
  assign is_last = (idx_r == head_cmd.nbytes);
  assign pop     = load && is_last;

  // Byte k after the lead is operand byte (nbytes - k), big-endian.
  assign byte_sel = head_cmd.nbytes - idx_r;
  assign shifted  = head_cmd.value >> {byte_sel[2:0], 3'b000};
  assign cur_byte = (idx_r == '0) ? head_cmd.lead : shifted[7:0];

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? '0 : idx_r + NB_W'(1);
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= cur_byte;
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  // Mid-command the head must stay put until its last byte leaves.
  `MVE_ASSERT(a_mid_cmd_has_head, clk, rst_n, (idx_r != '0) |-> head_valid, "idx without head")
  `MVE_ASSERT(a_idx_range, clk, rst_n, head_valid |-> (idx_r <= head_cmd.nbytes), "idx overrun")
  `MVE_ASSERT(a_pop_restarts, clk, rst_n, pop |=> (idx_r == '0), "idx not cleared on pop")
  `MVE_ASSERT(a_pop_marks_last, clk, rst_n, pop |=> (out_valid_r && out_last_r), "last missing")

endmodule

// ===== rtl/msgpack_value_encoder_top.sv =====
// ----------------------------------------------------------------------------
// MessagePack value encoder, top level
// Turns (mode, value) items into big-endian MessagePack byte transactions.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake           payload
//   -------  ---  ------------------  ---------------------------------
//   in_      in   in_valid/in_stall   in_mode[3:0], in_value[63:0]
//   out_     out  out_valid/out_stall out_byte[7:0], out_last
//
// Each defined item yields 1 to 9 output transactions, one per cycle while
// out_stall is low; single-byte items (fixints, nil, bool, fix headers, raw
// bytes) flow at one per cycle while out_stall is low. A longer item occupies
// the serializer and keeps its queue entry until its last byte loads, so one
// more item is accepted while those bytes drain before in_stall rises. Each
// item passes through a queue entry, then the output register, to out_byte.
// rst_n is synchronous, active low; it empties the queue and output stage.
// out_stall freezes the output register; in_stall rises only when the queue
// is full. Undefined modes are accepted and produce no transaction.
//
module msgpack_value_encoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_mode,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import mve_pkg::*;

  // Front-to-back command path.
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic head_valid;

  // Front: classify and choose the shortest encoding.
  mve_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_value (in_value),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  // Queue: decouples input acceptance from multi-byte drain.
  mve_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // Back: emit lead byte then operand bytes, MSB first.
  mve_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
